### sv/sda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_pkg: shared definitions for the sensor decimating averager
// Widths, window constants, register indexes, channel order and the
// structs passed between the top level, the lanes and the merge stage.
// ----------------------------------------------------------------------------
package sda_pkg;

    // Window and channel configuration
    localparam int WINDOW_LENGTH = 10;     // items per window, 2..16
    localparam int CHANNELS      = 8;      // lanes in use, 1..8
    localparam int SAMPLE_BITS   = 12;     // significant sample bits, 8..16

    localparam int NUM_IN    = 8;          // channel fields on the port
    localparam int SAMPLE_W  = 12;         // sample port width
    localparam int AVG_W     = 12;         // average field width
    localparam int SUM_W     = 16;         // running sum width (saturating)
    localparam int DIFF_W    = 13;         // signed difference fields
    localparam int LINE_W    = 3;
    localparam int CNT_W     = $clog2(WINDOW_LENGTH);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Divide by WINDOW_LENGTH as multiply by rounded-up reciprocal, then shift
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
    localparam longint DIV_MULT_L =
        ((64'd1 << DIV_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
    localparam int MULT_W    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_CENTER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] GATE_THRESHOLD_RST = 12'd2048;
    localparam logic [CFG_W-1:0] SERVO_CENTER_RST   = 12'd2048;
    localparam logic [CFG_W-1:0] LINE_THRESHOLD_RST = 12'd500;

    // Channel order
    localparam int CH_POT       = 0;
    localparam int CH_GATE      = 1;
    localparam int CH_FAR_LEFT  = 2;
    localparam int CH_LEFT      = 3;
    localparam int CH_CENTER    = 4;
    localparam int CH_FAR_RIGHT = 5;
    localparam int CH_RIGHT     = 6;
    localparam int CH_BATTERY   = 7;

    typedef logic [NUM_IN-1:0][AVG_W-1:0] t_avg_vec;

    // Per-transfer control broadcast to every lane
    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic window_end;   // this transfer closes the window
    } t_lane_ctl;

    typedef struct packed {
        logic [CFG_W-1:0] gate_threshold;
        logic [CFG_W-1:0] servo_center;
        logic [CFG_W-1:0] line_threshold;
    } t_cfg;

endpackage

### sv/sensor_decimating_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_decimating_averager: eight-channel boxcar decimating averager
// Sums eight sensor channels over a window and emits per-window averages
// with line bits, start gate flag, lateral error and servo angle.
// ----------------------------------------------------------------------------
// One input transfer per clock is taken whenever the result path can move:
// every channel has its own lane that adds the sample into a saturating
// 16-bit sum in the cycle of the transfer, so the sustained rate is one item
// per cycle. The tenth transfer of a window first freezes the sum of each
// lane into an average (multiply by the reciprocal of ten, registered in the
// lane), then restarts the sum with the current sample; after reset the
// first window therefore holds nine samples. The averages pass through a
// merge stage that derives line bits, gate flag and the signed differences
// and holds the result in an output register behind the lane averages.
// Input ready only drops when both the lane averages and the output
// register hold results that are not yet taken. The user must write
// threshold and center registers through the plain write port while the
// block is idle, unenforced by the block; writes to index 3 are ignored.
// ----------------------------------------------------------------------------
module sensor_decimating_averager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [sda_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sda_pkg::CFG_W-1:0]        i_cfg_data,
    // sample channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [sda_pkg::SAMPLE_W-1:0]     i_pot_sample,
    input  logic [sda_pkg::SAMPLE_W-1:0]     i_gate_sample,
    input  logic [sda_pkg::SAMPLE_W-1:0]     i_far_left_sample,
    input  logic [sda_pkg::SAMPLE_W-1:0]     i_left_sample,
    input  logic [sda_pkg::SAMPLE_W-1:0]     i_center_sample,
    input  logic [sda_pkg::SAMPLE_W-1:0]     i_far_right_sample,
    input  logic [sda_pkg::SAMPLE_W-1:0]     i_right_sample,
    input  logic [sda_pkg::SAMPLE_W-1:0]     i_battery_sample,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sda_pkg::AVG_W-1:0]        o_pot_avg,
    output logic [sda_pkg::AVG_W-1:0]        o_gate_avg,
    output logic [sda_pkg::AVG_W-1:0]        o_far_left_avg,
    output logic [sda_pkg::AVG_W-1:0]        o_left_avg,
    output logic [sda_pkg::AVG_W-1:0]        o_center_avg,
    output logic [sda_pkg::AVG_W-1:0]        o_far_right_avg,
    output logic [sda_pkg::AVG_W-1:0]        o_right_avg,
    output logic [sda_pkg::AVG_W-1:0]        o_battery_avg,
    output logic [sda_pkg::LINE_W-1:0]       o_line_bits,
    output logic                             o_gate_open,
    output logic signed [sda_pkg::DIFF_W-1:0] o_lateral_error,
    output logic signed [sda_pkg::DIFF_W-1:0] o_servo_angle
);

    sda_pkg::t_cfg                          r_cfg;
    logic [sda_pkg::CNT_W-1:0]              r_count;
    logic                                   r_a_valid;
    logic                                   w_a_ready;
    logic                                   w_accept;
    logic                                   w_window_end;
    sda_pkg::t_lane_ctl                     w_ctl;
    logic [sda_pkg::NUM_IN-1:0][sda_pkg::SAMPLE_W-1:0] w_samples;
    sda_pkg::t_avg_vec                      w_lane_avg;
    sda_pkg::t_avg_vec                      w_out_avg;

    // ---- configuration registers --------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_threshold <= sda_pkg::GATE_THRESHOLD_RST;
            r_cfg.servo_center   <= sda_pkg::SERVO_CENTER_RST;
            r_cfg.line_threshold <= sda_pkg::LINE_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sda_pkg::CFG_GATE_THRESHOLD: r_cfg.gate_threshold <= i_cfg_data;
                sda_pkg::CFG_SERVO_CENTER:   r_cfg.servo_center   <= i_cfg_data;
                sda_pkg::CFG_LINE_THRESHOLD: r_cfg.line_threshold <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---- input handshake and window counter ---------------------------
    // Input may move when the lane average registers are free or drain now.
    assign o_in_ready   = !r_a_valid || w_a_ready;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_window_end = (r_count == sda_pkg::CNT_W'(sda_pkg::WINDOW_LENGTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= w_window_end ? '0 : r_count + 1'b1;
        end
    end

    // lane averages hold a result between window end and hand-off to merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_accept && w_window_end) begin
            r_a_valid <= 1'b1;
        end else if (w_a_ready) begin
            r_a_valid <= 1'b0;
        end
    end

    assign w_ctl.accept     = w_accept;
    assign w_ctl.window_end = w_window_end;

    // ---- lanes ----------------------------------------------------------
    assign w_samples[sda_pkg::CH_POT]       = i_pot_sample;
    assign w_samples[sda_pkg::CH_GATE]      = i_gate_sample;
    assign w_samples[sda_pkg::CH_FAR_LEFT]  = i_far_left_sample;
    assign w_samples[sda_pkg::CH_LEFT]      = i_left_sample;
    assign w_samples[sda_pkg::CH_CENTER]    = i_center_sample;
    assign w_samples[sda_pkg::CH_FAR_RIGHT] = i_far_right_sample;
    assign w_samples[sda_pkg::CH_RIGHT]     = i_right_sample;
    assign w_samples[sda_pkg::CH_BATTERY]   = i_battery_sample;

    for (genvar g = 0; g < sda_pkg::NUM_IN; g++) begin : g_lane
        if (g < sda_pkg::CHANNELS) begin : g_used
            sda_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_sample (w_samples[g]),
                .o_avg    (w_lane_avg[g])
            );
        end else begin : g_unused
            // channel never summed: average reads zero
            assign w_lane_avg[g] = '0;
        end
    end

    // ---- merge and output register --------------------------------------
    sda_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_a_valid       (r_a_valid),
        .o_a_ready       (w_a_ready),
        .i_avg           (w_lane_avg),
        .i_cfg           (r_cfg),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_avg           (w_out_avg),
        .o_line_bits     (o_line_bits),
        .o_gate_open     (o_gate_open),
        .o_lateral_error (o_lateral_error),
        .o_servo_angle   (o_servo_angle)
    );

    assign o_pot_avg       = w_out_avg[sda_pkg::CH_POT];
    assign o_gate_avg      = w_out_avg[sda_pkg::CH_GATE];
    assign o_far_left_avg  = w_out_avg[sda_pkg::CH_FAR_LEFT];
    assign o_left_avg      = w_out_avg[sda_pkg::CH_LEFT];
    assign o_center_avg    = w_out_avg[sda_pkg::CH_CENTER];
    assign o_far_right_avg = w_out_avg[sda_pkg::CH_FAR_RIGHT];
    assign o_right_avg     = w_out_avg[sda_pkg::CH_RIGHT];
    assign o_battery_avg   = w_out_avg[sda_pkg::CH_BATTERY];

`ifndef SYNTHESIS
    // counter stays inside the window
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sda_pkg::CNT_W'(sda_pkg::WINDOW_LENGTH - 1))
        else $error("window counter out of range");

    // a window-closing transfer always leaves a pending average set
    a_window_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_window_end) |=> r_a_valid)
        else $error("window end did not capture averages");

    // pending averages move into an empty output register at once
    a_merge_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !o_out_valid) |=> o_out_valid)
        else $error("averages stuck while output empty");

    // a result that is not yet taken never leaves the output
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result lost under backpressure");
`endif

endmodule

### sv/sda_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_lane: one channel accumulator
// Saturating running sum; at window end the sum is divided by the window
// length into a registered average and restarts from the current sample.
// ----------------------------------------------------------------------------
module sda_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sda_pkg::t_lane_ctl           i_ctl,
    input  logic [sda_pkg::SAMPLE_W-1:0] i_sample,
    output logic [sda_pkg::AVG_W-1:0]    o_avg
);

    logic [sda_pkg::SUM_W-1:0]  r_sum;
    logic [sda_pkg::SUM_W-1:0]  n_sum;
    logic [sda_pkg::SUM_W-1:0]  w_sample;
    logic [sda_pkg::SUM_W:0]    w_add;
    logic [sda_pkg::PROD_W-1:0] w_prod;
    logic [sda_pkg::AVG_W-1:0]  r_avg;

    // bits above SAMPLE_BITS are dropped
    always_comb begin
        w_sample = sda_pkg::SUM_W'(i_sample)
                 & sda_pkg::SUM_W'((64'd1 << sda_pkg::SAMPLE_BITS) - 64'd1);
    end

    assign w_add  = {1'b0, r_sum} + {1'b0, w_sample};
    assign w_prod = sda_pkg::PROD_W'(r_sum) * sda_pkg::PROD_W'(sda_pkg::DIV_MULT);

    always_comb begin
        if (i_ctl.window_end) begin
            n_sum = w_sample;
        end else if (w_add[sda_pkg::SUM_W]) begin
            n_sum = sda_pkg::SUM_MAX;
        end else begin
            n_sum = w_add[sda_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.accept) begin
            r_sum <= n_sum;
        end
    end

    // quotient masked to the average width
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_ctl.window_end) begin
            r_avg <= w_prod[sda_pkg::DIV_SHIFT +: sda_pkg::AVG_W];
        end
    end

    assign o_avg = r_avg;

endmodule

### sv/sda_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_merge: result stage
// Combines the lane averages into line bits, gate flag and signed
// differences, and holds the finished result until it is taken.
// ----------------------------------------------------------------------------
module sda_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_a_valid,
    output logic                        o_a_ready,
    input  sda_pkg::t_avg_vec           i_avg,
    input  sda_pkg::t_cfg               i_cfg,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sda_pkg::t_avg_vec           o_avg,
    output logic [sda_pkg::LINE_W-1:0]  o_line_bits,
    output logic                        o_gate_open,
    output logic signed [sda_pkg::DIFF_W-1:0] o_lateral_error,
    output logic signed [sda_pkg::DIFF_W-1:0] o_servo_angle
);

    logic                              r_valid;
    logic                              w_load;
    sda_pkg::t_avg_vec                 r_avg;
    logic [sda_pkg::LINE_W-1:0]        r_line, n_line;
    logic                              r_gate, n_gate;
    logic signed [sda_pkg::DIFF_W-1:0] r_lat, n_lat;
    logic signed [sda_pkg::DIFF_W-1:0] r_servo, n_servo;

    assign o_a_ready = !r_valid || i_out_ready;
    assign w_load    = i_a_valid && o_a_ready;

    always_comb begin
        n_line[0] = i_avg[sda_pkg::CH_FAR_RIGHT] < i_cfg.line_threshold;
        n_line[1] = i_avg[sda_pkg::CH_CENTER]    < i_cfg.line_threshold;
        n_line[2] = i_avg[sda_pkg::CH_FAR_LEFT]  < i_cfg.line_threshold;
        n_gate    = i_avg[sda_pkg::CH_GATE] <= i_cfg.gate_threshold;
        n_lat     = $signed({1'b0, i_avg[sda_pkg::CH_RIGHT]})
                  - $signed({1'b0, i_avg[sda_pkg::CH_LEFT]});
        n_servo   = $signed({1'b0, i_cfg.servo_center})
                  - $signed({1'b0, i_avg[sda_pkg::CH_POT]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_avg   <= i_avg;
            r_line  <= n_line;
            r_gate  <= n_gate;
            r_lat   <= n_lat;
            r_servo <= n_servo;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_avg           = r_avg;
    assign o_line_bits     = r_line;
    assign o_gate_open     = r_gate;
    assign o_lateral_error = r_lat;
    assign o_servo_angle   = r_servo;

endmodule

### sim/sensor_decimating_averager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_decimating_averager_tb: self-checking bench for the window averager
// Drives sensor scans through the sample channel, predicts every window
// result in a local model of sums and thresholds, and compares each result
// transfer field by field. Random idling on both sides, threshold changes
// between phases and one long result stall that backs up the input.
// ----------------------------------------------------------------------------
module sensor_decimating_averager_tb;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int CLK_HALF_NS       = 4;
    localparam int RESET_CYCLES      = 7;
    localparam int MAX_IDLE          = 6;       // per-transfer idle draw, both sides
    localparam int LONG_STALL_CYCLES = 300;     // receiver hold-off for backpressure
    localparam int SETTLE_CYCLES     = 6;       // result path is two stages deep
    localparam int TAIL_CYCLES       = 20;
    localparam int WATCHDOG_NS       = 1_000_000;
    localparam int RANDOM_PHASES     = 7;
    localparam int PHASE_SCANS       = 110;
    localparam int STALL_SCANS       = 80;

    localparam logic [sda_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;   // not decoded
    localparam logic [sda_pkg::SAMPLE_W-1:0]  FULL_SCALE    = 12'hFFF;

    typedef logic [sda_pkg::NUM_IN-1:0][sda_pkg::SAMPLE_W-1:0] t_scan;

    typedef struct packed {
        sda_pkg::t_avg_vec                  avg;
        logic [sda_pkg::LINE_W-1:0]         line_bits;
        logic                               gate_open;
        logic signed [sda_pkg::DIFF_W-1:0]  lateral_error;
        logic signed [sda_pkg::DIFF_W-1:0]  servo_angle;
    } t_window_avg;

    // ------------------------------------------------------------------------
    // DUT signals, inputs at known values from time zero
    // ------------------------------------------------------------------------
    logic                               i_clk              = 1'b0;
    logic                               i_rst_n            = 1'b0;
    logic                               i_cfg_we           = 1'b0;
    logic [sda_pkg::CFG_IDX_W-1:0]      i_cfg_index        = '0;
    logic [sda_pkg::CFG_W-1:0]          i_cfg_data         = '0;
    logic                               i_in_valid         = 1'b0;
    logic                               o_in_ready;
    logic [sda_pkg::SAMPLE_W-1:0]       i_pot_sample       = '0;
    logic [sda_pkg::SAMPLE_W-1:0]       i_gate_sample      = '0;
    logic [sda_pkg::SAMPLE_W-1:0]       i_far_left_sample  = '0;
    logic [sda_pkg::SAMPLE_W-1:0]       i_left_sample      = '0;
    logic [sda_pkg::SAMPLE_W-1:0]       i_center_sample    = '0;
    logic [sda_pkg::SAMPLE_W-1:0]       i_far_right_sample = '0;
    logic [sda_pkg::SAMPLE_W-1:0]       i_right_sample     = '0;
    logic [sda_pkg::SAMPLE_W-1:0]       i_battery_sample   = '0;
    logic                               o_out_valid;
    logic                               i_out_ready        = 1'b0;
    logic [sda_pkg::AVG_W-1:0]          o_pot_avg;
    logic [sda_pkg::AVG_W-1:0]          o_gate_avg;
    logic [sda_pkg::AVG_W-1:0]          o_far_left_avg;
    logic [sda_pkg::AVG_W-1:0]          o_left_avg;
    logic [sda_pkg::AVG_W-1:0]          o_center_avg;
    logic [sda_pkg::AVG_W-1:0]          o_far_right_avg;
    logic [sda_pkg::AVG_W-1:0]          o_right_avg;
    logic [sda_pkg::AVG_W-1:0]          o_battery_avg;
    logic [sda_pkg::LINE_W-1:0]         o_line_bits;
    logic                               o_gate_open;
    logic signed [sda_pkg::DIFF_W-1:0]  o_lateral_error;
    logic signed [sda_pkg::DIFF_W-1:0]  o_servo_angle;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Shadow of the block: window position, running sums, thresholds
    int                         scans_in_window = 0;
    logic [sda_pkg::SUM_W-1:0]  channel_sum [sda_pkg::NUM_IN];
    logic [sda_pkg::CFG_W-1:0]  gate_thr  = sda_pkg::GATE_THRESHOLD_RST;
    logic [sda_pkg::CFG_W-1:0]  servo_ctr = sda_pkg::SERVO_CENTER_RST;
    logic [sda_pkg::CFG_W-1:0]  line_thr  = sda_pkg::LINE_THRESHOLD_RST;

    t_window_avg        pending_windows [$];   // predicted, not yet seen
    int                 mismatch_count = 0;

    // Idle control shared between the stimulus and the result sink
    bit                 sender_no_gaps = 1'b0;
    bit                 sink_no_gaps   = 1'b0;
    bit                 long_stall_req = 1'b0;

    // Random scan shaping: per-channel mode and level, redrawn per window
    int                 chan_mode  [sda_pkg::NUM_IN];
    int                 chan_level [sda_pkg::NUM_IN];

    string avg_names [sda_pkg::NUM_IN] = '{"pot_avg", "gate_avg", "far_left_avg",
                                           "left_avg", "center_avg", "far_right_avg",
                                           "right_avg", "battery_avg"};

    // ------------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------------
    sensor_decimating_averager i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_pot_sample       (i_pot_sample),
        .i_gate_sample      (i_gate_sample),
        .i_far_left_sample  (i_far_left_sample),
        .i_left_sample      (i_left_sample),
        .i_center_sample    (i_center_sample),
        .i_far_right_sample (i_far_right_sample),
        .i_right_sample     (i_right_sample),
        .i_battery_sample   (i_battery_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_pot_avg          (o_pot_avg),
        .o_gate_avg         (o_gate_avg),
        .o_far_left_avg     (o_far_left_avg),
        .o_left_avg         (o_left_avg),
        .o_center_avg       (o_center_avg),
        .o_far_right_avg    (o_far_right_avg),
        .o_right_avg        (o_right_avg),
        .o_battery_avg      (o_battery_avg),
        .o_line_bits        (o_line_bits),
        .o_gate_open        (o_gate_open),
        .o_lateral_error    (o_lateral_error),
        .o_servo_angle      (o_servo_angle)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Window predictor. Called once per accepted scan. The closing scan of a
    // window first turns the sums into a result and clears them, and only
    // then adds its own samples, so the first window after reset is one
    // scan short.
    // ------------------------------------------------------------------------
    function automatic void accumulate_scan(input t_scan s);
        t_window_avg                r;
        logic [sda_pkg::SUM_W:0]    acc;
        logic [sda_pkg::SUM_W-1:0]  sample;
        scans_in_window++;
        if (scans_in_window >= sda_pkg::WINDOW_LENGTH) begin
            scans_in_window = 0;
            for (int ch = 0; ch < sda_pkg::NUM_IN; ch++) begin
                r.avg[ch] = sda_pkg::AVG_W'(channel_sum[ch] / sda_pkg::WINDOW_LENGTH);
                channel_sum[ch] = '0;
            end
            // strictly below threshold counts as line seen
            r.line_bits = {r.avg[sda_pkg::CH_FAR_LEFT] < line_thr,
                           r.avg[sda_pkg::CH_CENTER] < line_thr,
                           r.avg[sda_pkg::CH_FAR_RIGHT] < line_thr};
            // gate open is inclusive of the threshold
            r.gate_open     = (r.avg[sda_pkg::CH_GATE] <= gate_thr);
            // differences wrap at 13 bits, which holds the full +/-4095 span
            r.lateral_error = sda_pkg::DIFF_W'({1'b0, r.avg[sda_pkg::CH_RIGHT]}
                                             - {1'b0, r.avg[sda_pkg::CH_LEFT]});
            r.servo_angle   = sda_pkg::DIFF_W'({1'b0, servo_ctr}
                                             - {1'b0, r.avg[sda_pkg::CH_POT]});
            pending_windows.push_back(r);
        end
        // only lanes in use accumulate; sums saturate instead of wrapping
        for (int ch = 0; ch < sda_pkg::CHANNELS && ch < sda_pkg::NUM_IN; ch++) begin
            sample = sda_pkg::SUM_W'(s[ch])
                   & sda_pkg::SUM_W'((32'd1 << sda_pkg::SAMPLE_BITS) - 1);
            acc    = {1'b0, channel_sum[ch]} + {1'b0, sample};
            channel_sum[ch] = (acc > {1'b0, sda_pkg::SUM_MAX}) ? sda_pkg::SUM_MAX
                                                               : acc[sda_pkg::SUM_W-1:0];
        end
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // ------------------------------------------------------------------------
    // Sample channel: one scan per call. Valid stays high between back-to-back
    // scans; it drops when an idle gap is drawn or while results are drained.
    // ------------------------------------------------------------------------
    task automatic send_scan(input t_scan s);
        int gap;
        gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_pot_sample       <= s[sda_pkg::CH_POT];
        i_gate_sample      <= s[sda_pkg::CH_GATE];
        i_far_left_sample  <= s[sda_pkg::CH_FAR_LEFT];
        i_left_sample      <= s[sda_pkg::CH_LEFT];
        i_center_sample    <= s[sda_pkg::CH_CENTER];
        i_far_right_sample <= s[sda_pkg::CH_FAR_RIGHT];
        i_right_sample     <= s[sda_pkg::CH_RIGHT];
        i_battery_sample   <= s[sda_pkg::CH_BATTERY];
        do @(posedge i_clk); while (!o_in_ready);
        accumulate_scan(s);
    endtask

    // Stop offering scans and wait until every predicted window has been
    // taken, then let the result pipeline go quiet.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three thresholds back to back, optionally followed by a write
    // to the undecoded index, which must leave everything unchanged.
    // Only called with the block idle.
    task automatic program_thresholds(input logic [sda_pkg::CFG_W-1:0] gate,
                                      input logic [sda_pkg::CFG_W-1:0] center,
                                      input logic [sda_pkg::CFG_W-1:0] line,
                                      input bit                        poke_spare);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sda_pkg::CFG_GATE_THRESHOLD;
        i_cfg_data  <= gate;
        @(posedge i_clk);
        gate_thr     = gate;
        i_cfg_index <= sda_pkg::CFG_SERVO_CENTER;
        i_cfg_data  <= center;
        @(posedge i_clk);
        servo_ctr    = center;
        i_cfg_index <= sda_pkg::CFG_LINE_THRESHOLD;
        i_cfg_data  <= line;
        @(posedge i_clk);
        line_thr     = line;
        if (poke_spare) begin
            i_cfg_index <= CFG_IDX_SPARE;
            i_cfg_data  <= sda_pkg::CFG_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_scan scan_of(input logic [sda_pkg::SAMPLE_W-1:0] pot, gate,
                                      far_left, left, center, far_right, right,
                                      battery);
        t_scan s;
        s[sda_pkg::CH_POT]       = pot;
        s[sda_pkg::CH_GATE]      = gate;
        s[sda_pkg::CH_FAR_LEFT]  = far_left;
        s[sda_pkg::CH_LEFT]      = left;
        s[sda_pkg::CH_CENTER]    = center;
        s[sda_pkg::CH_FAR_RIGHT] = far_right;
        s[sda_pkg::CH_RIGHT]     = right;
        s[sda_pkg::CH_BATTERY]   = battery;
        return s;
    endfunction

    task automatic send_repeated(input t_scan s, input int count);
        repeat (count) send_scan(s);
    endtask

    // ------------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------------
    // Thresholds: mostly anywhere, with the rails weighted in
    function automatic logic [sda_pkg::CFG_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FULL_SCALE;
            default: return sda_pkg::CFG_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Per channel: free-running noise, a steady level with jitter (so the
    // average lands near a chosen value and the threshold compares flip
    // both ways), or rail values.
    function automatic void redraw_channel_shapes();
        for (int ch = 0; ch < sda_pkg::NUM_IN; ch++) begin
            chan_mode[ch]  = $urandom_range(0, 3);
            chan_level[ch] = $urandom_range(0, 4095);
        end
    endfunction

    function automatic t_scan random_scan();
        t_scan s;
        int    v;
        for (int ch = 0; ch < sda_pkg::NUM_IN; ch++) begin
            case (chan_mode[ch])
                0: s[ch] = sda_pkg::SAMPLE_W'($urandom_range(0, 4095));
                3: s[ch] = $urandom_range(0, 1) ? FULL_SCALE : '0;
                default: begin
                    v = chan_level[ch] + $urandom_range(0, 64) - 32;
                    if (v < 0)    v = 0;
                    if (v > 4095) v = 4095;
                    s[ch] = sda_pkg::SAMPLE_W'(v);
                end
            endcase
        end
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Scan that drives lateral error and servo angle to the positive rails
    // (right full, left zero, pot zero) with mixed line channels.
    function automatic t_scan pos_rail_scan();
        return scan_of('0, '0, '0, '0, FULL_SCALE, '0, FULL_SCALE, FULL_SCALE);
    endfunction

    function automatic t_scan neg_rail_scan();
        return scan_of(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE, '0, FULL_SCALE,
                       '0, '0);
    endfunction

    // Reset thresholds, all-full-scale input. The first window only sees nine
    // scans, so every average is 9*4095/10. The tenth scan closes it and
    // opens the next window with the positive-rail pattern.
    task automatic test_short_first_window();
        send_repeated({sda_pkg::NUM_IN{FULL_SCALE}}, sda_pkg::WINDOW_LENGTH - 1);
        send_scan(pos_rail_scan());
        wait_results_drained();
    endtask

    // Full windows at the output rails with thresholds at the extremes:
    // gate average equal to the gate threshold counts as open, an average
    // equal to the line threshold does not count as line. Also checks that
    // a write to the undecoded register index has no effect.
    task automatic test_output_extremes();
        program_thresholds('0, FULL_SCALE, FULL_SCALE, 1'b1);
        send_repeated(pos_rail_scan(), sda_pkg::WINDOW_LENGTH - 1);
        send_scan(neg_rail_scan());
        wait_results_drained();
        program_thresholds(FULL_SCALE, '0, '0, 1'b1);
        send_repeated(neg_rail_scan(), sda_pkg::WINDOW_LENGTH - 1);
        send_scan('0);
        wait_results_drained();
    endtask

    // One phase of random traffic under fresh random thresholds. Now and
    // then the sender stops until every result is back.
    task automatic test_random_traffic(input int count);
        program_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                           $urandom_range(0, 1));
        for (int n = 0; n < count; n++) begin
            if (n % sda_pkg::WINDOW_LENGTH == 0)
                redraw_channel_shapes();
            send_scan(random_scan());
            if ($urandom_range(0, 99) == 0)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    // The sink parks for a long stretch while scans keep coming back to
    // back, so both result registers fill and input ready must drop.
    task automatic test_backpressure();
        sender_no_gaps = 1'b1;
        long_stall_req = 1'b1;
        for (int n = 0; n < STALL_SCANS; n++) begin
            if (n % sda_pkg::WINDOW_LENGTH == 0)
                redraw_channel_shapes();
            send_scan(random_scan());
        end
        sender_no_gaps = 1'b0;
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        for (int ch = 0; ch < sda_pkg::NUM_IN; ch++)
            channel_sum[ch] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_first_window();
        test_output_extremes();
        // phases with and without idling on either side
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sender_no_gaps = (p == 2) || (p == 5);
            sink_no_gaps   = (p == 3) || (p == 5);
            test_random_traffic(PHASE_SCANS);
        end
        sender_no_gaps = 1'b0;
        sink_no_gaps   = 1'b0;
        test_backpressure();

        // final quiet time: anything arriving now is unexpected
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result sink: after each transfer draw an idle stretch with ready low,
    // then hold ready high until the next transfer. A pending long-stall
    // request replaces one draw.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_stall_req) begin
                hold           = LONG_STALL_CYCLES;
                long_stall_req = 1'b0;
            end else begin
                hold = sink_no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transfer against the oldest prediction
    // ------------------------------------------------------------------------
    initial begin : result_checker
        t_window_avg got;
        t_window_avg want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.avg[sda_pkg::CH_POT]       = o_pot_avg;
                got.avg[sda_pkg::CH_GATE]      = o_gate_avg;
                got.avg[sda_pkg::CH_FAR_LEFT]  = o_far_left_avg;
                got.avg[sda_pkg::CH_LEFT]      = o_left_avg;
                got.avg[sda_pkg::CH_CENTER]    = o_center_avg;
                got.avg[sda_pkg::CH_FAR_RIGHT] = o_far_right_avg;
                got.avg[sda_pkg::CH_RIGHT]     = o_right_avg;
                got.avg[sda_pkg::CH_BATTERY]   = o_battery_avg;
                got.line_bits                  = o_line_bits;
                got.gate_open                  = o_gate_open;
                got.lateral_error              = o_lateral_error;
                got.servo_angle                = o_servo_angle;
                if (pending_windows.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = pending_windows.pop_front();
                    for (int ch = 0; ch < sda_pkg::NUM_IN; ch++)
                        if (got.avg[ch] !== want.avg[ch])
                            report_mismatch(avg_names[ch], got.avg[ch], want.avg[ch]);
                    if (got.line_bits !== want.line_bits)
                        report_mismatch("line_bits", got.line_bits, want.line_bits);
                    if (got.gate_open !== want.gate_open)
                        report_mismatch("gate_open", got.gate_open, want.gate_open);
                    if (got.lateral_error !== want.lateral_error)
                        report_mismatch("lateral_error", got.lateral_error,
                                        want.lateral_error);
                    if (got.servo_angle !== want.servo_angle)
                        report_mismatch("servo_angle", got.servo_angle, want.servo_angle);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a hung handshake ends the run as a failure
    // ------------------------------------------------------------------------
    initial begin : watchdog
        #WATCHDOG_NS;
        $display("TIMEOUT waiting on handshake, %0d results outstanding",
                 pending_windows.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
sv/sda_pkg.sv
sv/sda_lane.sv
sv/sda_merge.sv
sv/sensor_decimating_averager.sv
sim/sensor_decimating_averager_tb.sv
